@@ hw/rtl/essc_pkg.sv @@
// Shared types and constants for the engine start/stop sequencer.
// Depends on nothing; essc_cfg, essc_step, the top level, the checker and the testbench import it.
package essc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ELAPSED_W  = 17;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_HOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_WAIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_WAIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_FITTED = 2'd3;

    localparam logic [15:0] BUTTON_HOLD_RST = 16'd300;
    localparam logic [15:0] START_WAIT_RST  = 16'd6000;
    localparam logic [15:0] STOP_WAIT_RST   = 16'd6000;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_POLL  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_STOP  = 2'd3;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_STARTING = 2'd1;
    localparam logic [1:0] PH_STOPPING = 2'd2;

    localparam logic [3:0] EV_NONE           = 4'd0;
    localparam logic [3:0] EV_START_ACCEPTED = 4'd1;
    localparam logic [3:0] EV_START_REFUSED  = 4'd2;
    localparam logic [3:0] EV_STOP_ACCEPTED  = 4'd3;
    localparam logic [3:0] EV_STOP_REFUSED   = 4'd4;
    localparam logic [3:0] EV_STARTED        = 4'd5;
    localparam logic [3:0] EV_START_FAILED   = 4'd6;
    localparam logic [3:0] EV_STOPPED        = 4'd7;
    localparam logic [3:0] EV_STOP_FAILED    = 4'd8;
    localparam logic [3:0] EV_RELEASED       = 4'd9;
    localparam logic [3:0] EV_IGNORED_BUSY   = 4'd10;
    localparam logic [3:0] EV_CODE_MAX       = EV_IGNORED_BUSY;

    typedef struct packed {
        logic [15:0] button_hold_ms;
        logic [15:0] start_wait_ms;
        logic [15:0] stop_wait_ms;
        logic        power_switch_fitted;
    } t_cfg;

    typedef struct packed {
        logic [1:0] mode;
        logic       run_known;
        logic       run_level;
        logic       power_known;
        logic       power_level;
    } t_item;

    typedef struct packed {
        logic       start_drive;
        logic       stop_drive;
        logic       publish_valid;
        logic       published_on;
        logic [3:0] event_code;
    } t_result;

endpackage

@@ hw/rtl/essc_in_if.sv @@
// Handshake channel that carries one sequencer input item.
// Depends on nothing.
interface essc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       run_known;
    logic       run_level;
    logic       power_known;
    logic       power_level;

    modport source (output valid, mode, run_known, run_level, power_known, power_level,
                    input ready);
    modport sink   (input valid, mode, run_known, run_level, power_known, power_level,
                    output ready);
endinterface

@@ hw/rtl/essc_out_if.sv @@
// Handshake channel that carries one sequencer result item.
// Depends on nothing.
interface essc_out_if;
    logic       valid;
    logic       ready;
    logic       start_drive;
    logic       stop_drive;
    logic       publish_valid;
    logic       published_on;
    logic [3:0] event_code;

    modport source (output valid, start_drive, stop_drive, publish_valid, published_on,
                    event_code, input ready);
    modport sink   (input valid, start_drive, stop_drive, publish_valid, published_on,
                    event_code, output ready);
endinterface

@@ hw/rtl/essc_cfg.sv @@
// Configuration register bank of the sequencer: hold time, wait limits, switch option.
// Depends on essc_pkg.
module essc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [essc_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [essc_pkg::CFG_DATA_W-1:0] i_data,
    output essc_pkg::t_cfg                 o_cfg
);
    import essc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_hold_ms      <= BUTTON_HOLD_RST;
            r_cfg.start_wait_ms       <= START_WAIT_RST;
            r_cfg.stop_wait_ms        <= STOP_WAIT_RST;
            r_cfg.power_switch_fitted <= 1'b0;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_BUTTON_HOLD:  r_cfg.button_hold_ms      <= i_data;
                CFG_START_WAIT:   r_cfg.start_wait_ms       <= i_data;
                CFG_STOP_WAIT:    r_cfg.stop_wait_ms        <= i_data;
                CFG_POWER_FITTED: r_cfg.power_switch_fitted <= i_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ hw/rtl/essc_step.sv @@
// Sequencer state and the one-pass decision logic that turns an item into a result.
// Depends on essc_pkg.
module essc_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  essc_pkg::t_item  i_item,
    input  essc_pkg::t_cfg   i_cfg,
    output essc_pkg::t_result o_res
);
    import essc_pkg::*;

    logic [1:0]           r_phase, n_phase;
    logic                 r_starter_held, n_starter_held;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                 r_start_line, n_start_line;
    logic                 r_stop_line, n_stop_line;

    logic       running;
    logic       power_on;
    logic       busy;
    logic       released;
    logic       sw_ok;
    logic       pub_valid;
    logic       pub_on;
    logic [3:0] ev;

    assign running  = i_item.run_known & i_item.run_level;
    assign power_on = i_item.power_known & i_item.power_level;
    assign busy     = (r_phase == PH_STARTING) || (r_phase == PH_STOPPING);
    assign sw_ok    = !i_cfg.power_switch_fitted || power_on;

    always_comb begin
        n_phase        = r_phase;
        n_starter_held = r_starter_held;
        n_elapsed      = r_elapsed;
        n_start_line   = r_start_line;
        n_stop_line    = r_stop_line;
        released       = 1'b0;
        pub_valid      = 1'b0;
        pub_on         = 1'b0;
        ev             = EV_NONE;
        unique case (i_item.mode)
            MODE_TICK: begin
                if (r_elapsed != ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
                if (r_phase == PH_STARTING) begin
                    if (r_starter_held && (n_elapsed > {1'b0, i_cfg.button_hold_ms})) begin
                        n_start_line   = 1'b0;
                        n_starter_held = 1'b0;
                        released       = 1'b1;
                    end
                    if (running) begin
                        n_start_line = 1'b0;
                        n_phase      = PH_IDLE;
                        pub_valid    = 1'b1;
                        pub_on       = 1'b1;
                        ev           = EV_STARTED;
                    end else if (n_elapsed > {1'b0, i_cfg.start_wait_ms}) begin
                        n_start_line = 1'b0;
                        n_phase      = PH_IDLE;
                        ev           = EV_START_FAILED;
                    end else if (released) begin
                        ev = EV_RELEASED;
                    end
                end else if (r_phase == PH_STOPPING) begin
                    if (!running) begin
                        n_stop_line = 1'b0;
                        n_phase     = PH_IDLE;
                        pub_valid   = 1'b1;
                        ev          = EV_STOPPED;
                    end else if (n_elapsed > {1'b0, i_cfg.stop_wait_ms}) begin
                        n_stop_line = 1'b0;
                        n_phase     = PH_IDLE;
                        ev          = EV_STOP_FAILED;
                    end
                end
            end
            MODE_POLL: begin
                if (!busy) begin
                    pub_valid = 1'b1;
                    pub_on    = running;
                end
            end
            MODE_START: begin
                if (busy) begin
                    ev = EV_IGNORED_BUSY;
                end else if (sw_ok && !running) begin
                    n_stop_line    = 1'b0;
                    n_start_line   = 1'b1;
                    n_starter_held = 1'b1;
                    n_phase        = PH_STARTING;
                    n_elapsed      = '0;
                    ev             = EV_START_ACCEPTED;
                end else begin
                    ev = EV_START_REFUSED;
                end
            end
            MODE_STOP: begin
                if (busy) begin
                    ev = EV_IGNORED_BUSY;
                end else if (running) begin
                    n_start_line = 1'b0;
                    n_stop_line  = 1'b1;
                    n_phase      = PH_STOPPING;
                    n_elapsed    = '0;
                    ev           = EV_STOP_ACCEPTED;
                end else begin
                    ev = EV_STOP_REFUSED;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_starter_held <= 1'b0;
            r_elapsed      <= '0;
            r_start_line   <= 1'b0;
            r_stop_line    <= 1'b0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_starter_held <= n_starter_held;
            r_elapsed      <= n_elapsed;
            r_start_line   <= n_start_line;
            r_stop_line    <= n_stop_line;
        end
    end

    assign o_res.start_drive   = n_start_line;
    assign o_res.stop_drive    = n_stop_line;
    assign o_res.publish_valid = pub_valid;
    assign o_res.published_on  = pub_on;
    assign o_res.event_code    = ev;
endmodule

@@ hw/rtl/engine_start_stop_sequencer_core.sv @@
// Engine start/stop sequencer top level: input register, decision step, result register.
// Depends on essc_pkg, essc_in_if, essc_out_if, essc_cfg and essc_step.
//
// The input channel i_item carries one tick, poll, start request or stop request per
// transfer, together with the run and power-switch sensor levels. Every input transfer
// yields exactly one transfer on o_result with the starter and stop line levels, an
// optional published on/off state and an event code.
// The input transfer fills the input register; the decision logic works on it and loads
// the result register, which raises result valid. Throughput is one item per cycle while
// o_result.ready stays high; the sequencer state is updated in the same cycle the result
// register is loaded, so consecutive items see each other's effects in order.
// When the receiver stalls, the result register holds its transfer, the input register
// fills, and i_item.ready drops until o_result.ready returns.
// Synchronous reset clears both pipeline registers, returns the sequencer to idle with
// both lines off, and loads the register defaults (hold 300 ms, both waits 6000 ms,
// no power switch). Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and
// take effect on the next item; write them only while no transfer is in flight.
module engine_start_stop_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    essc_in_if.sink                         i_item,
    essc_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [essc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [essc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import essc_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result step_res;
    t_result r_out;
    logic    r_out_valid;
    logic    out_free;
    logic    advance;
    logic    in_take;

    assign out_free     = !r_out_valid || o_result.ready;
    assign advance      = r_in_valid && out_free;
    assign i_item.ready = !r_in_valid || out_free;
    assign in_take      = i_item.valid && i_item.ready;

    essc_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.mode        <= i_item.mode;
            r_in.run_known   <= i_item.run_known;
            r_in.run_level   <= i_item.run_level;
            r_in.power_known <= i_item.power_known;
            r_in.power_level <= i_item.power_level;
        end
    end

    essc_step u_step (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (advance),
        .i_item (r_in),
        .i_cfg  (cfg),
        .o_res  (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.start_drive   = r_out.start_drive;
    assign o_result.stop_drive    = r_out.stop_drive;
    assign o_result.publish_valid = r_out.publish_valid;
    assign o_result.published_on  = r_out.published_on;
    assign o_result.event_code    = r_out.event_code;
endmodule

@@ hw/rtl/essc_checker.sv @@
// Port-level checks for the engine start/stop sequencer, bound to the top level.
// Depends on essc_pkg and engine_start_stop_sequencer_core.
module essc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_start_drive,
    input logic       i_stop_drive,
    input logic       i_publish_valid,
    input logic       i_published_on,
    input logic [3:0] i_event_code
);
    import essc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_lines_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_start_drive && i_stop_drive))
        else $error("starter and stop lines driven together");

    a_publish_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_publish_valid) |-> !i_published_on)
        else $error("published state set without publish");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_code <= EV_CODE_MAX))
        else $error("event code out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_event_code) && $stable(i_start_drive)))
        else $error("stalled result changed");
endmodule

bind engine_start_stop_sequencer_core essc_checker u_essc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_start_drive  (o_result.start_drive),
    .i_stop_drive   (o_result.stop_drive),
    .i_publish_valid(o_result.publish_valid),
    .i_published_on (o_result.published_on),
    .i_event_code   (o_result.event_code)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for engine_start_stop_sequencer_core.
// Depends on essc_pkg, essc_in_if, essc_out_if and the core; a built-in sequencer model
// predicts every result transfer, which is then compared field by field.
module testbench;
    import essc_pkg::*;

    localparam int PIPE_LATENCY   = 2;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ROUND_ITEMS    = 170;
    localparam int RANDOM_ROUNDS  = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    essc_in_if  item_ch ();
    essc_out_if result_ch ();

    engine_start_stop_sequencer_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Sequencer model state and register copies.
    logic [1:0]           seq_phase;
    logic                 starter_held;
    logic                 start_line;
    logic                 stop_line;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [15:0]          hold_ms;
    logic [15:0]          start_wait_ms;
    logic [15:0]          stop_wait_ms;
    logic                 power_fitted;

    t_result pending_results[$];
    int      send_idle_pct;
    int      recv_stall_pct;
    int      errors;
    int      items_sent;
    int      results_checked;
    int      settings_used;
    int      stall_cycles;
    int      event_tally[16];
    logic    engine_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_item build_item(input logic [1:0] mode, input logic run_known,
                                         input logic run_level, input logic power_known,
                                         input logic power_level);
        t_item it;
        it.mode        = mode;
        it.run_known   = run_known;
        it.run_level   = run_level;
        it.power_known = power_known;
        it.power_level = power_level;
        return it;
    endfunction

    function automatic t_result advance_sequencer(input t_item it);
        logic    running;
        logic    power_on;
        logic    busy;
        logic    released;
        t_result r;
        running  = it.run_known && it.run_level;
        power_on = it.power_known && it.power_level;
        busy     = (seq_phase == PH_STARTING) || (seq_phase == PH_STOPPING);
        released = 1'b0;
        r        = '0;
        if (it.mode == MODE_TICK) begin
            if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;
            if (seq_phase == PH_STARTING) begin
                if (starter_held && elapsed_ms > hold_ms) begin
                    start_line   = 1'b0;
                    starter_held = 1'b0;
                    released     = 1'b1;
                end
                if (running) begin
                    start_line      = 1'b0;
                    seq_phase       = PH_IDLE;
                    r.publish_valid = 1'b1;
                    r.published_on  = 1'b1;
                    r.event_code    = EV_STARTED;
                end else if (elapsed_ms > start_wait_ms) begin
                    start_line   = 1'b0;
                    seq_phase    = PH_IDLE;
                    r.event_code = EV_START_FAILED;
                end else if (released) begin
                    r.event_code = EV_RELEASED;
                end
            end else if (seq_phase == PH_STOPPING) begin
                if (!running) begin
                    stop_line       = 1'b0;
                    seq_phase       = PH_IDLE;
                    r.publish_valid = 1'b1;
                    r.event_code    = EV_STOPPED;
                end else if (elapsed_ms > stop_wait_ms) begin
                    stop_line    = 1'b0;
                    seq_phase    = PH_IDLE;
                    r.event_code = EV_STOP_FAILED;
                end
            end
        end else if (it.mode == MODE_POLL) begin
            if (!busy) begin
                r.publish_valid = 1'b1;
                r.published_on  = running;
            end
        end else if (busy) begin
            r.event_code = EV_IGNORED_BUSY;
        end else if (it.mode == MODE_START) begin
            if ((!power_fitted || power_on) && !running) begin
                stop_line    = 1'b0;
                start_line   = 1'b1;
                starter_held = 1'b1;
                seq_phase    = PH_STARTING;
                elapsed_ms   = '0;
                r.event_code = EV_START_ACCEPTED;
            end else begin
                r.event_code = EV_START_REFUSED;
            end
        end else begin
            if (running) begin
                start_line   = 1'b0;
                stop_line    = 1'b1;
                seq_phase    = PH_STOPPING;
                elapsed_ms   = '0;
                r.event_code = EV_STOP_ACCEPTED;
            end else begin
                r.event_code = EV_STOP_REFUSED;
            end
        end
        r.start_drive = start_line;
        r.stop_drive  = stop_line;
        return r;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= it.mode;
        item_ch.run_known   <= it.run_known;
        item_ch.run_level   <= it.run_level;
        item_ch.power_known <= it.power_known;
        item_ch.power_level <= it.power_level;
        do @(posedge i_clk); while (!item_ch.ready);
        pending_results.push_back(advance_sequencer(it));
        items_sent++;
    endtask

    // Called right after a transfer: stops sending until every result has come back.
    task automatic pause_until_drained();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_registers(input logic [15:0] hold, input logic [15:0] start_wait,
                                  input logic [15:0] stop_wait, input logic fitted);
        logic [CFG_IDX_W-1:0]  reg_idx[4];
        logic [CFG_DATA_W-1:0] reg_val[4];
        reg_idx = '{CFG_BUTTON_HOLD, CFG_START_WAIT, CFG_STOP_WAIT, CFG_POWER_FITTED};
        reg_val = '{hold, start_wait, stop_wait, {15'd0, fitted}};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_idx[k];
            i_cfg_data <= reg_val[k];
            @(posedge i_clk);
        end
        i_cfg_we      <= 1'b0;
        hold_ms       = hold;
        start_wait_ms = start_wait;
        stop_wait_ms  = stop_wait;
        power_fitted  = fitted;
        settings_used++;
    endtask

    task automatic send_ticks(input int count, input logic running);
        repeat (count) send_item(build_item(MODE_TICK, 1'b1, running, 1'b1, 1'b1));
    endtask

    // Starter release at the reset hold time, then a start and a stop that both succeed.
    task automatic test_reset_defaults();
        send_item(build_item(MODE_POLL, 1'b1, 1'b1, 1'b0, 1'b0));
        send_item(build_item(MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(build_item(MODE_START, 1'b1, 1'b0, 1'b0, 1'b0));
        send_ticks(301, 1'b0);
        send_ticks(1, 1'b1);
        send_item(build_item(MODE_STOP, 1'b0, 1'b1, 1'b1, 1'b1));
        send_item(build_item(MODE_STOP, 1'b1, 1'b1, 1'b1, 1'b0));
        send_ticks(5, 1'b1);
        send_ticks(1, 1'b0);
        send_item(build_item(MODE_POLL, 1'b1, 1'b0, 1'b1, 1'b1));
        pause_until_drained();
    endtask

    task automatic test_power_switch();
        load_registers(16'd5, 16'd10, 16'd10, 1'b1);
        send_item(build_item(MODE_START, 1'b1, 1'b0, 1'b0, 1'b1));
        send_item(build_item(MODE_START, 1'b1, 1'b0, 1'b1, 1'b0));
        send_item(build_item(MODE_START, 1'b1, 1'b1, 1'b1, 1'b1));
        send_item(build_item(MODE_START, 1'b0, 1'b1, 1'b1, 1'b1));
        send_ticks(11, 1'b0);
        pause_until_drained();
    endtask

    task automatic test_start_outcomes();
        load_registers(16'd3, 16'd8, 16'd8, 1'b0);
        send_item(build_item(MODE_START, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(build_item(MODE_POLL, 1'b1, 1'b1, 1'b0, 1'b0));
        send_item(build_item(MODE_START, 1'b1, 1'b0, 1'b1, 1'b1));
        send_item(build_item(MODE_STOP, 1'b1, 1'b1, 1'b1, 1'b1));
        send_ticks(4, 1'b0);
        send_ticks(1, 1'b1);
        pause_until_drained();
        load_registers(16'd0, 16'd0, 16'd8, 1'b0);
        send_item(build_item(MODE_START, 1'b1, 1'b0, 1'b0, 1'b0));
        send_ticks(1, 1'b0);
        pause_until_drained();
        load_registers(16'd0, 16'hFFFF, 16'd8, 1'b0);
        send_item(build_item(MODE_START, 1'b1, 1'b0, 1'b0, 1'b0));
        send_ticks(1, 1'b1);
        pause_until_drained();
        load_registers(16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_item(build_item(MODE_START, 1'b1, 1'b0, 1'b0, 1'b0));
        send_ticks(1, 1'b0);
        pause_until_drained();
    endtask

    task automatic test_stop_outcomes();
        load_registers(16'd0, 16'd0, 16'hFFFF, 1'b0);
        send_item(build_item(MODE_STOP, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(build_item(MODE_STOP, 1'b1, 1'b1, 1'b0, 1'b0));
        send_item(build_item(MODE_START, 1'b1, 1'b0, 1'b1, 1'b1));
        send_item(build_item(MODE_POLL, 1'b1, 1'b0, 1'b0, 1'b0));
        send_ticks(2, 1'b1);
        send_ticks(1, 1'b0);
        send_item(build_item(MODE_POLL, 1'b1, 1'b0, 1'b0, 1'b0));
        pause_until_drained();
        load_registers(16'd0, 16'd0, 16'd0, 1'b0);
        send_item(build_item(MODE_STOP, 1'b1, 1'b1, 1'b0, 1'b0));
        send_ticks(1, 1'b1);
        send_ticks(1, 1'b1);
        pause_until_drained();
    endtask

    // The engine state drifts slowly, so most starts and stops run to a real outcome.
    function automatic t_item random_item();
        int   pick;
        logic run_known;
        logic run_level;
        if ($urandom_range(99) < 8) engine_on = ~engine_on;
        pick      = $urandom_range(99);
        run_known = ($urandom_range(9) != 0);
        run_level = run_known ? (engine_on ^ ($urandom_range(19) == 0)) : 1'($urandom);
        return build_item(pick < 55 ? MODE_TICK : pick < 67 ? MODE_POLL :
                          pick < 84 ? MODE_START : MODE_STOP,
                          run_known, run_level, $urandom_range(9) != 0,
                          $urandom_range(3) != 0);
    endfunction

    task automatic test_random_traffic();
        int wait_span;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            wait_span = (round == RANDOM_ROUNDS - 1) ? 120 : 20;
            load_registers(16'($urandom_range(wait_span / 2)), 16'($urandom_range(wait_span)),
                           16'($urandom_range(wait_span)), 1'(round % 2));
            case (round % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                send_item(random_item());
                if (round == 2 && n == ROUND_ITEMS / 2) pause_until_drained();
            end
            pause_until_drained();
        end
    endtask

    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic compare_field(input string field_name, input int expected,
                                 input int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, got %0d", field_name, expected, actual);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        t_result exp_r;
        if (i_rst_n) begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else if (result_ch.valid && result_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    compare_field("start_drive", exp_r.start_drive, result_ch.start_drive);
                    compare_field("stop_drive", exp_r.stop_drive, result_ch.stop_drive);
                    compare_field("publish_valid", exp_r.publish_valid,
                                  result_ch.publish_valid);
                    compare_field("published_on", exp_r.published_on, result_ch.published_on);
                    compare_field("event_code", exp_r.event_code, result_ch.event_code);
                    event_tally[exp_r.event_code]++;
                    results_checked++;
                end
            end
        end
    end

    initial begin
        item_ch.valid       <= 1'b0;
        item_ch.mode        <= MODE_TICK;
        item_ch.run_known   <= 1'b0;
        item_ch.run_level   <= 1'b0;
        item_ch.power_known <= 1'b0;
        item_ch.power_level <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_BUTTON_HOLD;
        i_cfg_data          <= '0;
        i_rst_n             <= 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        errors          = 0;
        items_sent      = 0;
        results_checked = 0;
        settings_used   = 1;
        stall_cycles    = 0;
        engine_on       = 1'b0;
        seq_phase       = PH_IDLE;
        starter_held    = 1'b0;
        start_line      = 1'b0;
        stop_line       = 1'b0;
        elapsed_ms      = '0;
        hold_ms         = BUTTON_HOLD_RST;
        start_wait_ms   = START_WAIT_RST;
        stop_wait_ms    = STOP_WAIT_RST;
        power_fitted    = 1'b0;
        foreach (event_tally[k]) event_tally[k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_power_switch();
        test_start_outcomes();
        test_stop_outcomes();
        test_random_traffic();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            errors++;
        end
        $display("Covered %0d items and %0d checked results over %0d register settings.",
                 items_sent, results_checked, settings_used);
        $display("Outcomes: %0d started, %0d start timeouts, %0d stopped, %0d stop timeouts.",
                 event_tally[EV_STARTED], event_tally[EV_START_FAILED],
                 event_tally[EV_STOPPED], event_tally[EV_STOP_FAILED]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
